FILE: rtl/tsdf_pkg.sv
// Shared types, register map and helpers for the tether spring-damper force block.
`default_nettype none
package tsdf_pkg;

  // Register map (word index = paddr[4:2])
  localparam int RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_ANCHOR_X = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ANCHOR_Y = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ANCHOR_Z = 3'd2;
  localparam logic [RegIdxW-1:0] REG_LEASH    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SPRING   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_DAMPER   = 3'd5;
  localparam int AddrW = 5;

  // Reset values (Q16.16)
  localparam logic [31:0] ANCHOR_X_RST = 32'd51118;
  localparam logic [31:0] ANCHOR_Y_RST = 32'd36045;
  localparam logic [31:0] ANCHOR_Z_RST = 32'd137626;
  localparam logic [30:0] LEASH_RST    = 31'd39322;
  localparam logic [30:0] SPRING_RST   = 31'd13107200;
  localparam logic [30:0] DAMPER_RST   = 31'd655360;

  // Pipeline geometry
  localparam int RootW  = 33;   // floor(sqrt) of a value below 2^66
  localparam int QuoW   = 31;   // unit vector magnitude, at most 2^30
  localparam int SqRemW = 68;
  localparam int DvRemW = 64;
  localparam int Latency = 74;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               force_active;
  } out_t;

  // Payload riding along the square-root stages
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } sq_car_t;

  // Payload riding along the divider stages
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [2:0]         sgn;
    logic [RootW-1:0]   radius;
    logic [RootW-1:0]   ext;
    logic               active;
  } dv_car_t;

  // Magnitude of a 33-bit signed difference
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tether_spring_damper_force.sv
// Top level: pipelined one-sided spring-damper tether force in three dimensions.
`default_nettype none
// One body beat (position and velocity, Q16.16) is taken whenever start is high; busy
// is always low, so a beat may be issued every cycle. Each beat gives exactly one result
// beat, shown for one cycle with out_valid. The pipeline is made of the square root (one
// stage per root bit, 33 stages) followed by the restoring divider for the unit vector
// (one stage per quotient bit, 31 stages), plus the input, square, sum, leash compare and
// six multiply/saturate stages. The receiver cannot stall the pipeline. The user must write
// registers over the APB port only while no beat is in flight; the block does not enforce it.
module tether_spring_damper_force (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire tsdf_pkg::in_t              in_data,
  output logic                            out_valid,
  output tsdf_pkg::out_t                  out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tsdf_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int NSq = tsdf_pkg::RootW;
  localparam int NDv = tsdf_pkg::QuoW;

  // ---------------- configuration registers ----------------
  logic [31:0] anchor_x_r, anchor_y_r, anchor_z_r;
  logic [30:0] leash_r, spring_r, damper_r;
  logic        wr_en;
  logic [tsdf_pkg::RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[tsdf_pkg::AddrW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_x_r <= tsdf_pkg::ANCHOR_X_RST;
      anchor_y_r <= tsdf_pkg::ANCHOR_Y_RST;
      anchor_z_r <= tsdf_pkg::ANCHOR_Z_RST;
      leash_r    <= tsdf_pkg::LEASH_RST;
      spring_r   <= tsdf_pkg::SPRING_RST;
      damper_r   <= tsdf_pkg::DAMPER_RST;
    end else if (wr_en) begin
      case (reg_idx)
        tsdf_pkg::REG_ANCHOR_X: anchor_x_r <= pwdata;
        tsdf_pkg::REG_ANCHOR_Y: anchor_y_r <= pwdata;
        tsdf_pkg::REG_ANCHOR_Z: anchor_z_r <= pwdata;
        tsdf_pkg::REG_LEASH:    leash_r    <= pwdata[30:0];
        tsdf_pkg::REG_SPRING:   spring_r   <= pwdata[30:0];
        tsdf_pkg::REG_DAMPER:   damper_r   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      tsdf_pkg::REG_ANCHOR_X: prdata = anchor_x_r;
      tsdf_pkg::REG_ANCHOR_Y: prdata = anchor_y_r;
      tsdf_pkg::REG_ANCHOR_Z: prdata = anchor_z_r;
      tsdf_pkg::REG_LEASH:    prdata = {1'b0, leash_r};
      tsdf_pkg::REG_SPRING:   prdata = {1'b0, spring_r};
      tsdf_pkg::REG_DAMPER:   prdata = {1'b0, damper_r};
      default:                prdata = '0;
    endcase
  end

  assign busy = 1'b0;

  // ---------------- stage A: differences ----------------
  logic             va_r;
  tsdf_pkg::sq_car_t ca_r;

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    ca_r.dx <= $signed({anchor_x_r[31], anchor_x_r}) - $signed({in_data.pos_x[31], in_data.pos_x});
    ca_r.dy <= $signed({anchor_y_r[31], anchor_y_r}) - $signed({in_data.pos_y[31], in_data.pos_y});
    ca_r.dz <= $signed({anchor_z_r[31], anchor_z_r}) - $signed({in_data.pos_z[31], in_data.pos_z});
    ca_r.vx <= in_data.vel_x;
    ca_r.vy <= in_data.vel_y;
    ca_r.vz <= in_data.vel_z;
  end

  // ---------------- stage B: squares ----------------
  logic             vb_r;
  tsdf_pkg::sq_car_t cb_r;
  logic [65:0]      sqx_r, sqy_r, sqz_r;
  logic [32:0]      mx, my, mz;

  assign mx = tsdf_pkg::mag33(ca_r.dx);
  assign my = tsdf_pkg::mag33(ca_r.dy);
  assign mz = tsdf_pkg::mag33(ca_r.dz);

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else        vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    cb_r  <= ca_r;
    sqx_r <= 66'(mx) * 66'(mx);
    sqy_r <= 66'(my) * 66'(my);
    sqz_r <= 66'(mz) * 66'(mz);
  end

  // ---------------- square root, one root bit per stage ----------------
  logic                          sq_v_r    [0:NSq];
  tsdf_pkg::sq_car_t             sq_c_r    [0:NSq];
  logic [tsdf_pkg::SqRemW-1:0]   sq_rem_r  [0:NSq];
  logic [tsdf_pkg::RootW-1:0]    sq_root_r [0:NSq];

  // stage C: sum of squares seeds the remainder
  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else        sq_v_r[0] <= vb_r;
  end

  always_ff @(posedge clk) begin
    sq_c_r[0]    <= cb_r;
    sq_rem_r[0]  <= 68'(sqx_r) + 68'(sqy_r) + 68'(sqz_r);
    sq_root_r[0] <= '0;
  end

  for (genvar k = 0; k < NSq; k++) begin : g_sqrt
    localparam int B = NSq - 1 - k;
    logic [tsdf_pkg::SqRemW-1:0] trial;
    logic                        take;

    assign trial = (68'(sq_root_r[k]) << (B + 1)) + (68'(1) << (2 * B));
    assign take  = sq_rem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else        sq_v_r[k+1] <= sq_v_r[k];
    end

    always_ff @(posedge clk) begin
      sq_c_r[k+1]    <= sq_c_r[k];
      sq_rem_r[k+1]  <= take ? sq_rem_r[k] - trial : sq_rem_r[k];
      sq_root_r[k+1] <= take ? (sq_root_r[k] | (33'(1) << B)) : sq_root_r[k];
    end
  end

  // ---------------- divider: u = |d| * 2^30 / radius, one quotient bit per stage -----
  logic                         dv_v_r   [0:NDv];
  tsdf_pkg::dv_car_t            dv_c_r   [0:NDv];
  logic [tsdf_pkg::DvRemW-1:0]  dv_rem_r [0:NDv][0:2];
  logic [tsdf_pkg::QuoW-1:0]    dv_q_r   [0:NDv][0:2];
  logic [tsdf_pkg::RootW-1:0]   radius;
  tsdf_pkg::sq_car_t            sq_end;

  assign radius = sq_root_r[NSq];
  assign sq_end = sq_c_r[NSq];

  // leash compare and divider seed
  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else        dv_v_r[0] <= sq_v_r[NSq];
  end

  always_ff @(posedge clk) begin
    dv_c_r[0].vx     <= sq_end.vx;
    dv_c_r[0].vy     <= sq_end.vy;
    dv_c_r[0].vz     <= sq_end.vz;
    dv_c_r[0].sgn    <= {sq_end.dz[32], sq_end.dy[32], sq_end.dx[32]};
    dv_c_r[0].radius <= radius;
    dv_c_r[0].ext    <= radius - {2'b00, leash_r};
    dv_c_r[0].active <= radius > {2'b00, leash_r};
    dv_rem_r[0][0]   <= 64'(tsdf_pkg::mag33(sq_end.dx)) << 30;
    dv_rem_r[0][1]   <= 64'(tsdf_pkg::mag33(sq_end.dy)) << 30;
    dv_rem_r[0][2]   <= 64'(tsdf_pkg::mag33(sq_end.dz)) << 30;
    dv_q_r[0][0]     <= '0;
    dv_q_r[0][1]     <= '0;
    dv_q_r[0][2]     <= '0;
  end

  for (genvar k = 0; k < NDv; k++) begin : g_div
    localparam int J = NDv - 1 - k;
    logic [tsdf_pkg::DvRemW-1:0] dsh;

    assign dsh = 64'(dv_c_r[k].radius) << J;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else        dv_v_r[k+1] <= dv_v_r[k];
    end

    always_ff @(posedge clk) begin
      dv_c_r[k+1] <= dv_c_r[k];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (dv_rem_r[k][l] >= dsh) begin
          dv_rem_r[k+1][l] <= dv_rem_r[k][l] - dsh;
          dv_q_r[k+1][l]   <= dv_q_r[k][l] | (31'(1) << J);
        end else begin
          dv_rem_r[k+1][l] <= dv_rem_r[k][l];
          dv_q_r[k+1][l]   <= dv_q_r[k][l];
        end
      end
    end
  end

  // ---------------- P1: radial products and spring product ----------------
  tsdf_pkg::dv_car_t  dv_end;
  logic signed [31:0] ux, uy, uz;
  logic               v1_r, act1_r;
  logic signed [31:0] ux1_r, uy1_r, uz1_r;
  logic signed [63:0] px_r, py_r, pz_r;
  logic [63:0]        sp_r;

  assign dv_end = dv_c_r[NDv];
  assign ux = dv_end.sgn[0] ? -$signed({1'b0, dv_q_r[NDv][0]}) : $signed({1'b0, dv_q_r[NDv][0]});
  assign uy = dv_end.sgn[1] ? -$signed({1'b0, dv_q_r[NDv][1]}) : $signed({1'b0, dv_q_r[NDv][1]});
  assign uz = dv_end.sgn[2] ? -$signed({1'b0, dv_q_r[NDv][2]}) : $signed({1'b0, dv_q_r[NDv][2]});

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= dv_v_r[NDv];
  end

  always_ff @(posedge clk) begin
    act1_r <= dv_end.active;
    ux1_r  <= ux;
    uy1_r  <= uy;
    uz1_r  <= uz;
    px_r   <= 64'(dv_end.vx) * 64'(ux);
    py_r   <= 64'(dv_end.vy) * 64'(uy);
    pz_r   <= 64'(dv_end.vz) * 64'(uz);
    sp_r   <= 64'(spring_r) * 64'(dv_end.ext);
  end

  // ---------------- P2: radial velocity, spring term ----------------
  logic signed [65:0] dot, dot_adj;
  logic               v2_r, act2_r;
  logic signed [31:0] ux2_r, uy2_r, uz2_r;
  logic signed [35:0] vr_r;
  logic [47:0]        s2_r;

  assign dot = $signed({{2{px_r[63]}}, px_r}) + $signed({{2{py_r[63]}}, py_r})
             + $signed({{2{pz_r[63]}}, pz_r});
  // truncate toward zero
  assign dot_adj = dot[65] ? dot + 66'sd1073741823 : dot;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    act2_r <= act1_r;
    ux2_r  <= ux1_r;
    uy2_r  <= uy1_r;
    uz2_r  <= uz1_r;
    vr_r   <= dot_adj[65:30];
    s2_r   <= sp_r[63:16];
  end

  // ---------------- P3: damper product ----------------
  logic               v3_r, act3_r;
  logic signed [31:0] ux3_r, uy3_r, uz3_r;
  logic [47:0]        s3_r;
  logic signed [67:0] dp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    act3_r <= act2_r;
    ux3_r  <= ux2_r;
    uy3_r  <= uy2_r;
    uz3_r  <= uz2_r;
    s3_r   <= s2_r;
    dp_r   <= 68'($signed({1'b0, damper_r})) * 68'(vr_r);
  end

  // ---------------- P4: force magnitude M = S - D ----------------
  logic signed [67:0] dp_adj;
  logic signed [52:0] m;
  logic               v4_r, act4_r, mneg4_r;
  logic signed [31:0] ux4_r, uy4_r, uz4_r;
  logic [51:0]        mm4_r;

  assign dp_adj = dp_r[67] ? dp_r + 68'sd65535 : dp_r;
  assign m      = $signed({5'b0, s3_r}) - $signed({dp_adj[67], dp_adj[67:16]});

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    act4_r  <= act3_r;
    ux4_r   <= ux3_r;
    uy4_r   <= uy3_r;
    uz4_r   <= uz3_r;
    mneg4_r <= m[52];
    mm4_r   <= m[52] ? 52'(-m) : 52'(m);
  end

  // ---------------- P5: split products M * u ----------------
  logic               v5_r, act5_r;
  logic [2:0]         neg5_r;
  logic [62:0]        pa_r [0:2];
  logic [50:0]        pb_r [0:2];
  logic signed [31:0] u4 [0:2];

  assign u4[0] = ux4_r;
  assign u4[1] = uy4_r;
  assign u4[2] = uz4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    act5_r <= act4_r;
  end

  for (genvar l = 0; l < 3; l++) begin : g_fmul
    logic [30:0] um;
    assign um = u4[l][31] ? 31'(-u4[l]) : 31'(u4[l]);

    always_ff @(posedge clk) begin
      neg5_r[l] <= mneg4_r ^ u4[l][31];
      pa_r[l]   <= 63'(mm4_r[31:0]) * 63'(um);
      pb_r[l]   <= 51'(mm4_r[51:32]) * 51'(um);
    end
  end

  // ---------------- P6: combine, saturate, output register ----------------
  logic signed [31:0] fo [0:2];

  for (genvar l = 0; l < 3; l++) begin : g_sat
    logic [55:0] f;
    assign f = {3'b0, pb_r[l], 2'b00} + 56'(pa_r[l][62:30]);

    always_comb begin
      if (!act5_r) begin
        fo[l] = '0;
      end else if (neg5_r[l] && f != '0) begin
        fo[l] = (f >= 56'h8000_0000) ? 32'sh8000_0000 : 32'(-f);
      end else begin
        fo[l] = (f > 56'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(f);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= v5_r;
  end

  always_ff @(posedge clk) begin
    out_data.force_x      <= fo[0];
    out_data.force_y      <= fo[1];
    out_data.force_z      <= fo[2];
    out_data.force_active <= act5_r;
  end

  // ---------------- assertions ----------------
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.force_active |->
      out_data.force_x == 0 && out_data.force_y == 0 && out_data.force_z == 0)
    else $error("inactive beat carries nonzero force");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, tsdf_pkg::Latency))
    else $error("result beat without a matching input beat");

  a_leash_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && reg_idx == tsdf_pkg::REG_LEASH |=> leash_r == $past(pwdata[30:0]))
    else $error("leash register write lost");

endmodule
`default_nettype wire
